[hdl/hps_pkg.sv]
// Shared types, widths and pattern tables for the haptic pattern sequencer.
// No dependencies.
package hps_pkg;

   localparam int DutyWidth    = 8;
   localparam int CmdWidth     = 8;
   localparam int PatternWidth = 3;
   localparam int SegWidth     = 4;
   localparam int MsWidth      = 11;

   localparam logic [CmdWidth-1:0]     LastCommand = 8'd6;
   localparam logic                    KindTick    = 1'b0;
   localparam logic                    KindStart   = 1'b1;

   typedef struct packed {
      logic                    playing;
      logic [PatternWidth-1:0] pattern_number;
      logic [SegWidth-1:0]     segment_index;
      logic [MsWidth-1:0]      ms_left;
   } state_type;

   typedef struct packed {
      logic [DutyWidth-1:0] motor_duty;
      logic                 busy_res;
      logic                 dropped;
      logic                 finished;
   } result_type;

   // Segment length in ms; segments past the end of a pattern read as zero.
   function automatic logic [MsWidth-1:0] seg_ms(input logic [PatternWidth-1:0] pat,
                                                 input logic [SegWidth-1:0] idx);
      logic [MsWidth-1:0] ms;
      ms = '0;
      unique case (pat)
         3'd1: begin
            if (idx == 4'd0 || idx == 4'd2) ms = 11'd300;
            else if (idx == 4'd1) ms = 11'd200;
         end
         3'd2: begin
            if (idx == 4'd0 || idx == 4'd2 || idx == 4'd4) ms = 11'd300;
            else if (idx == 4'd1 || idx == 4'd3) ms = 11'd200;
         end
         3'd3: begin
            if (idx == 4'd0) ms = 11'd1000;
         end
         3'd4: begin
            if (idx == 4'd0 || idx == 4'd1) ms = 11'd200;
            else if (idx == 4'd2) ms = 11'd800;
         end
         3'd5: begin
            if (idx <= 4'd8) ms = idx[0] ? 11'd100 : 11'd150;
         end
         3'd6: begin
            if (idx == 4'd0 || idx == 4'd2) ms = 11'd1000;
            else if (idx == 4'd1) ms = 11'd200;
         end
         default: begin
            if (idx == 4'd0) ms = 11'd500;
         end
      endcase
      return ms;
   endfunction

   function automatic logic [SegWidth:0] seg_count(input logic [PatternWidth-1:0] pat);
      logic [SegWidth:0] cnt;
      unique case (pat)
         3'd1:    cnt = 5'd3;
         3'd2:    cnt = 5'd5;
         3'd4:    cnt = 5'd3;
         3'd5:    cnt = 5'd9;
         3'd6:    cnt = 5'd3;
         default: cnt = 5'd1;
      endcase
      return cnt;
   endfunction

endpackage

[hdl/hps_step.sv]
// Next-state and result logic for one item of the haptic pattern sequencer.
// Depends on hps_pkg for the state and result types and the pattern tables.
module hps_step (
   input  hps_pkg::state_type                   cur_state,
   input  logic                                 kind,
   input  logic [hps_pkg::CmdWidth-1:0]         command_id,
   input  logic [hps_pkg::DutyWidth-1:0]        on_duty,
   output hps_pkg::state_type                   nxt_state,
   output hps_pkg::result_type                  result
);

   logic [hps_pkg::PatternWidth-1:0] start_pat;
   logic [hps_pkg::MsWidth-1:0]      ms_dec;
   logic [hps_pkg::SegWidth:0]       seg_plus;
   logic                             drop;
   logic                             fin;

   assign start_pat = (command_id <= hps_pkg::LastCommand) ?
                      command_id[hps_pkg::PatternWidth-1:0] : '0;
   assign ms_dec    = (cur_state.ms_left != '0) ? cur_state.ms_left - 1'b1 : '0;
   assign seg_plus  = {1'b0, cur_state.segment_index} + 1'b1;

   always_comb begin
      nxt_state = cur_state;
      drop      = 1'b0;
      fin       = 1'b0;
      if (kind == hps_pkg::KindStart) begin
         if (cur_state.playing) begin
            drop = 1'b1;
         end else begin
            nxt_state.playing        = 1'b1;
            nxt_state.pattern_number = start_pat;
            nxt_state.segment_index  = '0;
            nxt_state.ms_left        = hps_pkg::seg_ms(start_pat, '0);
         end
      end else if (cur_state.playing) begin
         nxt_state.ms_left = ms_dec;
         if (ms_dec == '0) begin
            // advance to the next segment, or end the pattern after the last one
            if (seg_plus >= hps_pkg::seg_count(cur_state.pattern_number)) begin
               nxt_state.playing       = 1'b0;
               nxt_state.segment_index = '0;
               fin                     = 1'b1;
            end else begin
               nxt_state.segment_index = seg_plus[hps_pkg::SegWidth-1:0];
               nxt_state.ms_left = hps_pkg::seg_ms(cur_state.pattern_number,
                                                   seg_plus[hps_pkg::SegWidth-1:0]);
            end
         end
      end
   end

   always_comb begin
      result.motor_duty = (nxt_state.playing && !nxt_state.segment_index[0]) ? on_duty : '0;
      result.busy_res   = nxt_state.playing;
      result.dropped    = drop;
      result.finished   = fin;
   end

endmodule

[hdl/haptic_pattern_sequencer.sv]
// Haptic pattern sequencer: one item enters the input register, is processed by hps_step
// and its result is held in the output register until transferred.
// Throughput: one item per cycle while rsp_stall does not hold a pending result;
// set by the single input-to-result register stage.
// Reset (synchronous, active high) clears valid bits and pattern state, on_duty to 200.
module haptic_pattern_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_kind,
   input  logic [hps_pkg::CmdWidth-1:0]   req_command_id,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [hps_pkg::DutyWidth-1:0]  rsp_motor_duty,
   output logic                           rsp_busy_res,
   output logic                           rsp_dropped,
   output logic                           rsp_finished,
   input  logic                           csr_wr_en,
   input  logic [hps_pkg::DutyWidth-1:0]  csr_wr_data
);

   logic                            in_valid_ff;
   logic                            in_kind_ff;
   logic [hps_pkg::CmdWidth-1:0]    in_cmd_ff;
   logic                            out_valid_ff;
   hps_pkg::result_type             out_res_ff;
   hps_pkg::state_type              state_ff;
   hps_pkg::state_type              state_in;
   hps_pkg::result_type             res_in;
   logic [hps_pkg::DutyWidth-1:0]   on_duty_ff;
   logic                            advance;
   logic                            req_xfer;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   hps_step u_step (
      .cur_state  (state_ff),
      .kind       (in_kind_ff),
      .command_id (in_cmd_ff),
      .on_duty    (on_duty_ff),
      .nxt_state  (state_in),
      .result     (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         on_duty_ff   <= 8'd200;
      end else begin
         if (csr_wr_en) begin
            on_duty_ff <= csr_wr_data;
         end
         if (req_xfer) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_kind_ff <= req_kind;
         in_cmd_ff  <= req_command_id;
      end
      if (advance) begin
         out_res_ff <= res_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_motor_duty = out_res_ff.motor_duty;
   assign rsp_busy_res   = out_res_ff.busy_res;
   assign rsp_dropped    = out_res_ff.dropped;
   assign rsp_finished   = out_res_ff.finished;

`ifndef SYNTHESIS
   a_finish_not_busy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_res_ff.finished) |-> !out_res_ff.busy_res)
      else $error("finished result still shows busy");

   a_drop_busy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_res_ff.dropped) |-> out_res_ff.busy_res)
      else $error("dropped command while idle");

   a_idle_seg_zero: assert property (@(posedge clock) disable iff (reset)
      !state_ff.playing |-> (state_ff.segment_index == '0))
      else $error("segment index nonzero while idle");

   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed item lost before result register");
`endif

endmodule
